@@ hdl/lkc_pkg.sv @@
// shared types and constants for the lru/lfu key-value cache
// no dependencies
`default_nettype none
package lkc_pkg;

    localparam int FIELD_BITS = 64;
    localparam int CFG_DATA_BITS = 4;

    typedef enum logic [1:0] {
        OP_GET = 2'd0,
        OP_PUT = 2'd1,
        OP_DEL = 2'd2,
        OP_NOP = 2'd3
    } t_op;

    typedef enum logic {
        CFG_POLICY   = 1'b0,
        CFG_CAPACITY = 1'b1
    } t_cfg_reg;

    typedef enum logic {
        POL_LRU = 1'b0,
        POL_LFU = 1'b1
    } t_policy;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } t_state;

    localparam logic [CFG_DATA_BITS-1:0] CAP_RESET = 4'd3;

endpackage
`default_nettype wire

@@ hdl/lkc_mem.sv @@
// entry store: one write port, one read port, registered read data
// no dependencies
`default_nettype none
module lkc_mem #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

@@ hdl/lru_lfu_key_value_cache_unit.sv @@
// key-value cache top level: request sequencer around the entry store
// depends on lkc_pkg and lkc_mem
// a request runs through a search pass and then a read-modify-write pass over the store,
// one entry per cycle through its read port; o_busy is high until the second pass ends,
// so a new request is taken only once the last one is through
// reset (synchronous, active low) clears valid bits, occupancy, state and flags; store contents
// need no clearing. results cannot be stalled: o_done is high for exactly one cycle
`default_nettype none
module lru_lfu_key_value_cache_unit
    import lkc_pkg::*;
#(
    parameter int ENTRIES    = 8,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 64,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    output logic                          o_busy,
    input  wire logic [1:0]               i_op,
    input  wire logic [FIELD_BITS-1:0]    i_key,
    input  wire logic [FIELD_BITS-1:0]    i_value,
    output logic                          o_done,
    output logic                          o_status,
    output logic [FIELD_BITS-1:0]         o_read_value,
    input  wire logic                     i_cfg_we,
    input  wire logic                     i_cfg_addr,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_wdata
);

    localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW   = $clog2(ENTRIES + 1);
    localparam int RECW = KEY_BITS + VALUE_BITS + IW + COUNT_BITS;
    localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    t_state r_state, n_state;

    logic                  r_policy;
    logic [CFG_DATA_BITS-1:0] r_cap;
    logic [ENTRIES-1:0]    r_valid;
    logic [CW-1:0]         r_occ;

    t_op                   r_op;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_val;

    logic [IW-1:0]         r_ptr;
    logic                  r_issued;
    logic                  r_pv;
    logic [IW-1:0]         r_pidx;

    logic                  r_hit;
    logic [IW-1:0]         r_hs;
    logic [IW-1:0]         r_hr;
    logic [VALUE_BITS-1:0] r_hdata;
    logic                  r_vf;
    logic [IW-1:0]         r_vs;
    logic [IW-1:0]         r_vr;
    logic [COUNT_BITS-1:0] r_vc;
    logic                  r_ff;
    logic [IW-1:0]         r_fs;

    logic                  r_done;
    logic                  r_status;
    logic [VALUE_BITS-1:0] r_rdata;

    logic                  rd_en;
    logic                  wr_en;
    logic [RECW-1:0]       q;
    logic [RECW-1:0]       wdata;

    logic [KEY_BITS-1:0]   q_key;
    logic [VALUE_BITS-1:0] q_data;
    logic [IW-1:0]         q_rank;
    logic [COUNT_BITS-1:0] q_cnt;
    logic                  q_vld;
    logic                  accept;
    logic                  last_proc;

    logic [7:0]            cap8, ent8, cap_eff, occ8;
    logic                  is_get, is_put, is_del;
    logic                  evict, ins_ok;
    logic [IW-1:0]         ins;
    logic                  better;

    logic [KEY_BITS-1:0]   w_key;
    logic [VALUE_BITS-1:0] w_data;
    logic [IW-1:0]         w_rank;
    logic [COUNT_BITS-1:0] w_cnt;
    logic                  w_vld;
    logic [COUNT_BITS-1:0] bumped;

    lkc_mem #(
        .WIDTH (RECW),
        .DEPTH (ENTRIES),
        .AW    (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_pidx),
        .i_wdata (wdata),
        .i_re    (rd_en),
        .i_raddr (r_ptr),
        .o_rdata (q)
    );

    assign accept    = i_start && (r_state == ST_IDLE);
    assign {q_key, q_data, q_rank, q_cnt} = q;
    assign q_vld     = r_valid[r_pidx];
    assign last_proc = r_pv && (r_pidx == LAST);

    assign is_get = (r_op == OP_GET);
    assign is_put = (r_op == OP_PUT);
    assign is_del = (r_op == OP_DEL);

    assign cap8    = {4'd0, r_cap};
    assign ent8    = 8'(ENTRIES);
    assign occ8    = 8'(r_occ);
    assign cap_eff = (cap8 == 8'd0) ? 8'd1 : ((cap8 > ent8) ? ent8 : cap8);
    assign evict   = is_put && !r_hit && (occ8 >= cap_eff) && r_vf;
    assign ins_ok  = is_put && !r_hit && (evict || r_ff);

    always_comb begin
        if (r_ff) begin
            ins = (evict && (r_vs < r_fs)) ? r_vs : r_fs;
        end else begin
            ins = r_vs;
        end
    end

    // victim order: lru takes the oldest, lfu the lowest count then the oldest
    always_comb begin
        if (r_policy == POL_LFU) begin
            better = (q_cnt < r_vc) || ((q_cnt == r_vc) && (q_rank > r_vr));
        end else begin
            better = q_rank > r_vr;
        end
    end

    assign bumped = ((r_policy == POL_LFU) && (q_cnt != CNT_MAX)) ? q_cnt + 1'b1 : q_cnt;

    // per-entry rewrite during the second pass
    always_comb begin
        w_key  = q_key;
        w_data = q_data;
        w_rank = q_rank;
        w_cnt  = q_cnt;
        w_vld  = q_vld;
        if ((is_get || is_put) && r_hit) begin
            if (r_pidx == r_hs) begin
                w_rank = '0;
                w_cnt  = bumped;
                if (is_put) begin
                    w_data = r_val;
                end
            end else if (q_vld && (q_rank < r_hr)) begin
                w_rank = q_rank + 1'b1;
            end
        end else if (ins_ok) begin
            if (r_pidx == ins) begin
                w_key  = r_key;
                w_data = r_val;
                w_rank = '0;
                w_cnt  = '0;
                w_vld  = 1'b1;
            end else if (evict && (r_pidx == r_vs)) begin
                w_vld = 1'b0;
            end else if (q_vld) begin
                w_rank = (evict && (q_rank > r_vr)) ? q_rank : q_rank + 1'b1;
            end
        end else if (is_del && r_hit) begin
            if (r_pidx == r_hs) begin
                w_vld = 1'b0;
            end else if (q_vld && (q_rank > r_hr)) begin
                w_rank = q_rank - 1'b1;
            end
        end
    end

    assign wdata = {w_key, w_data, w_rank, w_cnt};

    always_comb begin
        unique case (r_state)
            ST_IDLE:   n_state = accept ? ST_SCAN : ST_IDLE;
            ST_SCAN:   n_state = last_proc ? ST_UPDATE : ST_SCAN;
            ST_UPDATE: n_state = last_proc ? ST_IDLE : ST_UPDATE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        unique case (r_state)
            ST_SCAN, ST_UPDATE: rd_en = !r_issued;
            default:            rd_en = 1'b0;
        endcase
        wr_en = (r_state == ST_UPDATE) && r_pv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_policy <= POL_LRU;
            r_cap    <= CAP_RESET;
            r_valid  <= '0;
            r_occ    <= '0;
            r_pv     <= 1'b0;
            r_issued <= 1'b0;
            r_ptr    <= '0;
            r_done   <= 1'b0;
            r_hit    <= 1'b0;
            r_vf     <= 1'b0;
            r_ff     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == ST_UPDATE) && last_proc;
            if (i_cfg_we) begin
                unique case (t_cfg_reg'(i_cfg_addr))
                    CFG_POLICY:   r_policy <= i_cfg_wdata[0];
                    CFG_CAPACITY: r_cap    <= i_cfg_wdata;
                    default:      r_cap    <= r_cap;
                endcase
            end
            // read issue pointer
            r_pv   <= rd_en;
            r_pidx <= r_ptr;
            if (rd_en) begin
                r_ptr <= r_ptr + 1'b1;
                if (r_ptr == LAST) begin
                    r_issued <= 1'b1;
                end
            end
            if (accept || (r_state == ST_SCAN && last_proc)) begin
                r_ptr    <= '0;
                r_issued <= 1'b0;
            end
            if (accept) begin
                r_op  <= t_op'(i_op);
                r_key <= i_key[KEY_BITS-1:0];
                r_val <= i_value[VALUE_BITS-1:0];
                r_hit <= 1'b0;
                r_vf  <= 1'b0;
                r_ff  <= 1'b0;
            end
            if (r_state == ST_SCAN && r_pv) begin
                if (q_vld) begin
                    if (!r_hit && (q_key == r_key)) begin
                        r_hit   <= 1'b1;
                        r_hs    <= r_pidx;
                        r_hr    <= q_rank;
                        r_hdata <= q_data;
                    end
                    if (!r_vf || better) begin
                        r_vf <= 1'b1;
                        r_vs <= r_pidx;
                        r_vr <= q_rank;
                        r_vc <= q_cnt;
                    end
                end else if (!r_ff) begin
                    r_ff <= 1'b1;
                    r_fs <= r_pidx;
                end
            end
            if (wr_en) begin
                r_valid[r_pidx] <= w_vld;
            end
            if (r_state == ST_UPDATE && last_proc) begin
                r_status <= !(is_put || ((is_get || is_del) && r_hit));
                r_rdata  <= (is_get && r_hit) ? r_hdata : '0;
                if (is_del && r_hit) begin
                    r_occ <= r_occ - 1'b1;
                end else if (ins_ok && !evict) begin
                    r_occ <= r_occ + 1'b1;
                end
            end
        end
    end

    assign o_busy       = (r_state != ST_IDLE);
    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_read_value = FIELD_BITS'(r_rdata);

endmodule
`default_nettype wire
